// ===== rtl/lzr_pkg.sv =====
// lzr_pkg: shared constants, state and phase types, and the command and
// status words passed between the LZSS decoder controller and datapath.
// No dependencies.
package lzr_pkg;

    localparam int WIN_SIZE = 4096;
    localparam int WIN_AW   = $clog2(WIN_SIZE);
    localparam int CNT_W    = 24;
    localparam int REM_W    = 5;

    localparam logic [CNT_W-1:0]  LIMIT_RST    = '1;
    localparam logic [CNT_W-1:0]  WIN_SIZE_CNT = CNT_W'(WIN_SIZE);
    localparam logic [WIN_AW-1:0] WP_START     = WIN_AW'(12'hFEE % WIN_SIZE);
    localparam logic [7:0]        FILL_BYTE    = 8'h20;
    localparam logic [REM_W-1:0]  MATCH_BIAS   = REM_W'(3);

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_MATCH
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_LIT,
        ST_RD,
        ST_WR,
        ST_OVF,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic set_flags;
        logic set_low;
        logic start_copy;
        logic issue_rd;
        logic emit_lit;
        logic emit_copy;
        logic emit_ovf;
        logic emit_done;
        logic rearm;
    } t_cmd;

    typedef struct packed {
        t_phase phase;
        logic   flag0;
        logic   halted;
        logic   in_last;
        logic   at_limit;
        logic   copy_end;
        logic   out_free;
    } t_stat;

endpackage

// ===== rtl/lzr_ram.sv =====
// lzr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lzr_ctrl.sv =====
// lzr_ctrl: sequencing state machine of the LZSS decoder.
// Depends on lzr_pkg (t_state, t_cmd, t_stat).
module lzr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_src_valid,
    output logic          o_src_stall,
    input  lzr_pkg::t_stat i_stat,
    output lzr_pkg::t_cmd  o_cmd
);
    import lzr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_src_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DEC;
                end
            end
            ST_DEC: begin
                if (i_stat.halted) begin
                    o_cmd.rearm = i_stat.in_last;
                    n_state     = ST_IDLE;
                end else begin
                    case (i_stat.phase)
                        PH_FLAG: begin
                            o_cmd.set_flags = 1'b1;
                            n_state = i_stat.in_last ? ST_DONE : ST_IDLE;
                        end
                        PH_TOKEN: begin
                            if (i_stat.flag0) begin
                                n_state = i_stat.at_limit ? ST_OVF : ST_LIT;
                            end else begin
                                o_cmd.set_low = 1'b1;
                                n_state = i_stat.in_last ? ST_DONE : ST_IDLE;
                            end
                        end
                        PH_MATCH: begin
                            o_cmd.start_copy = 1'b1;
                            n_state          = ST_RD;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_lit = 1'b1;
                    n_state = i_stat.in_last ? ST_DONE : ST_IDLE;
                end
            end
            ST_RD: begin
                if (i_stat.at_limit) begin
                    n_state = ST_OVF;
                end else begin
                    o_cmd.issue_rd = 1'b1;
                    n_state        = ST_WR;
                end
            end
            ST_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_copy = 1'b1;
                    if (i_stat.copy_end) begin
                        n_state = i_stat.in_last ? ST_DONE : ST_IDLE;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_OVF: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_ovf = 1'b1;
                    o_cmd.rearm    = i_stat.in_last;
                    n_state        = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    o_cmd.rearm     = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_src_stall = (r_state != ST_IDLE);

    // copy byte always follows its RAM read
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR && $past(r_state) != ST_WR) |-> $past(r_state) == ST_RD)
        else $error("copy emit without preceding read");

    // an accepted word is always decoded next
    a_accept_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_src_valid && !o_src_stall) |=> r_state == ST_DEC)
        else $error("accepted word not decoded");

endmodule

// ===== rtl/lzr_dpath.sv =====
// lzr_dpath: LZSS decoder datapath - token state, byte count, window ring,
// copy pointer and the result register.
// Depends on lzr_pkg and lzr_ram.
module lzr_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [lzr_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic [7:0]                 i_src_byte,
    input  logic                       i_src_last,
    input  logic                       i_res_stall,
    input  lzr_pkg::t_cmd              i_cmd,
    output lzr_pkg::t_stat             o_stat,
    output logic                       o_res_valid,
    output logic [7:0]                 o_out_byte,
    output logic                       o_has_byte,
    output logic                       o_run_last,
    output logic                       o_stream_done,
    output logic                       o_overflow,
    output logic [lzr_pkg::CNT_W-1:0]  o_written_total
);
    import lzr_pkg::*;

    // control state
    t_phase             r_phase, n_phase;
    logic [2:0]         r_tok, n_tok;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_halted, n_halted;
    logic [WIN_AW-1:0]  r_wp, n_wp;
    logic [CNT_W-1:0]   r_limit, n_limit;
    logic               r_in_last, n_in_last;
    logic               r_out_valid, n_out_valid;
    // payload
    logic [7:0]         r_flags, n_flags;
    logic [7:0]         r_low, n_low;
    logic [7:0]         r_in_byte, n_in_byte;
    logic [WIN_AW-1:0]  r_cpos, n_cpos;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [7:0]         r_out_byte, n_out_byte;
    logic               r_has_byte, n_has_byte;
    logic               r_run_last, n_run_last;
    logic               r_done, n_done;
    logic               r_ovf, n_ovf;
    logic [CNT_W-1:0]   r_total, n_total;

    logic               ram_we;
    logic [7:0]         ram_wdata;
    logic [7:0]         ram_rdata;
    logic [WIN_AW-1:0]  fill_off;
    logic               fill_ok;
    logic [7:0]         copy_byte;
    logic               copy_end;
    logic               tok_done;

    lzr_ram #(
        .WIDTH (8),
        .DEPTH (WIN_SIZE)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.issue_rd),
        .i_raddr (r_cpos),
        .o_rdata (ram_rdata)
    );

    // ring entries are written in order from WP_START, so an entry is live
    // once the stream byte count has passed its distance from the start
    assign fill_off  = r_cpos - WP_START;
    assign fill_ok   = (r_count >= WIN_SIZE_CNT) || (CNT_W'(fill_off) < r_count);
    assign copy_byte = fill_ok ? ram_rdata : FILL_BYTE;
    assign copy_end  = (r_rem == REM_W'(1));
    assign tok_done  = i_cmd.emit_lit || (i_cmd.emit_copy && copy_end);

    always_comb begin
        n_phase     = r_phase;
        n_tok       = r_tok;
        n_count     = r_count;
        n_halted    = r_halted;
        n_wp        = r_wp;
        n_limit     = r_limit;
        n_in_last   = r_in_last;
        n_out_valid = r_out_valid && i_res_stall;
        n_flags     = r_flags;
        n_low       = r_low;
        n_in_byte   = r_in_byte;
        n_cpos      = r_cpos;
        n_rem       = r_rem;
        n_out_byte  = r_out_byte;
        n_has_byte  = r_has_byte;
        n_run_last  = r_run_last;
        n_done      = r_done;
        n_ovf       = r_ovf;
        n_total     = r_total;
        ram_we      = 1'b0;
        ram_wdata   = i_cmd.emit_lit ? r_in_byte : copy_byte;

        if (i_cfg_valid) begin
            n_limit = i_cfg_data;
        end
        if (i_cmd.load_in) begin
            n_in_byte = i_src_byte;
            n_in_last = i_src_last;
        end
        if (i_cmd.set_flags) begin
            n_flags = r_in_byte;
            n_tok   = '0;
            n_phase = PH_TOKEN;
        end
        if (i_cmd.set_low) begin
            n_low   = r_in_byte;
            n_phase = PH_MATCH;
        end
        if (i_cmd.start_copy) begin
            n_cpos = WIN_AW'({r_in_byte[7:4], r_low});
            n_rem  = REM_W'(r_in_byte[3:0]) + MATCH_BIAS;
        end
        if (i_cmd.emit_lit || i_cmd.emit_copy) begin
            ram_we      = 1'b1;
            n_wp        = r_wp + 1'b1;
            n_count     = r_count + 1'b1;
            n_out_valid = 1'b1;
            n_out_byte  = ram_wdata;
            n_has_byte  = 1'b1;
            n_run_last  = tok_done && !r_in_last;
            n_done      = 1'b0;
            n_ovf       = 1'b0;
            n_total     = r_count + 1'b1;
        end
        if (i_cmd.emit_copy) begin
            n_cpos = r_cpos + 1'b1;
            n_rem  = r_rem - 1'b1;
        end
        if (tok_done) begin
            n_flags = {1'b0, r_flags[7:1]};
            n_tok   = r_tok + 1'b1;
            n_phase = (&r_tok) ? PH_FLAG : PH_TOKEN;
        end
        if (i_cmd.emit_ovf || i_cmd.emit_done) begin
            n_out_valid = 1'b1;
            n_out_byte  = '0;
            n_has_byte  = 1'b0;
            n_run_last  = 1'b1;
            n_done      = 1'b1;
            n_ovf       = i_cmd.emit_ovf;
            n_total     = r_count;
        end
        if (i_cmd.emit_ovf) begin
            n_halted = 1'b1;
        end
        if (i_cmd.rearm) begin
            n_phase  = PH_FLAG;
            n_tok    = '0;
            n_count  = '0;
            n_halted = 1'b0;
            n_wp     = WP_START;
            n_low    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FLAG;
            r_tok       <= '0;
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_wp        <= WP_START;
            r_limit     <= LIMIT_RST;
            r_in_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_tok       <= n_tok;
            r_count     <= n_count;
            r_halted    <= n_halted;
            r_wp        <= n_wp;
            r_limit     <= n_limit;
            r_in_last   <= n_in_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags    <= n_flags;
        r_low      <= n_low;
        r_in_byte  <= n_in_byte;
        r_cpos     <= n_cpos;
        r_rem      <= n_rem;
        r_out_byte <= n_out_byte;
        r_has_byte <= n_has_byte;
        r_run_last <= n_run_last;
        r_done     <= n_done;
        r_ovf      <= n_ovf;
        r_total    <= n_total;
    end

    always_comb begin
        o_stat          = '0;
        o_stat.phase    = r_phase;
        o_stat.flag0    = r_flags[0];
        o_stat.halted   = r_halted;
        o_stat.in_last  = r_in_last;
        o_stat.at_limit = (r_count >= r_limit);
        o_stat.copy_end = copy_end;
        o_stat.out_free = !r_out_valid || !i_res_stall;
    end

    assign o_res_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_has_byte      = r_has_byte;
    assign o_run_last      = r_run_last;
    assign o_stream_done   = r_done;
    assign o_overflow      = r_ovf;
    assign o_written_total = r_total;

    // never overwrite a word still waiting at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_lit || i_cmd.emit_copy || i_cmd.emit_ovf || i_cmd.emit_done)
        |-> (!r_out_valid || !i_res_stall))
        else $error("result register overwritten while stalled");

    // overflow status closes both the step and the stream
    a_ovf_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ovf) |-> (r_run_last && r_done && !r_has_byte))
        else $error("overflow result not final");

    // copy length is never exhausted while a copy byte is emitted
    a_rem_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_copy |-> (r_rem != '0))
        else $error("copy emitted with zero length left");

endmodule

// ===== rtl/lzss_ring_decoder.sv =====
// lzss_ring_decoder: top level of the LZSS decoder, 4 KiB ring window.
// Depends on lzr_pkg, lzr_ctrl, lzr_dpath (and lzr_ram through lzr_dpath).
//
// Takes one compressed byte per input word and emits decoded bytes, one per
// output word, followed by status-only words for end of stream (src_last)
// and for hitting the configured output limit. Each input word passes the
// controller's accept and decode states; a literal adds an emit state, and
// a match adds a ring read, then an emit/write, per copied byte, holding the
// input until its last byte is copied. The ring RAM has a single read and a
// single write port and a registered read, so each copied byte needs a ring
// read ahead of its emit. No clearing pass is needed after reset or at stream
// end: the ring is filled in order from 0xFEE, so the stream byte count tells
// which entries are live, and others read as spaces. out_limit may be written
// only while the decoder is idle; the config channel is always ready.
module lzss_ring_decoder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // config write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [lzr_pkg::CNT_W-1:0] i_cfg_data,
    // compressed input words
    input  logic                      i_src_valid,
    output logic                      o_src_stall,
    input  logic [7:0]                i_src_byte,
    input  logic                      i_src_last,
    // decoded result words
    output logic                      o_res_valid,
    input  logic                      i_res_stall,
    output logic [7:0]                o_out_byte,
    output logic                      o_has_byte,
    output logic                      o_run_last,
    output logic                      o_stream_done,
    output logic                      o_overflow,
    output logic [lzr_pkg::CNT_W-1:0] o_written_total
);
    import lzr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    lzr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_src_valid (i_src_valid),
        .o_src_stall (o_src_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lzr_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_src_byte      (i_src_byte),
        .i_src_last      (i_src_last),
        .i_res_stall     (i_res_stall),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_res_valid     (o_res_valid),
        .o_out_byte      (o_out_byte),
        .o_has_byte      (o_has_byte),
        .o_run_last      (o_run_last),
        .o_stream_done   (o_stream_done),
        .o_overflow      (o_overflow),
        .o_written_total (o_written_total)
    );

endmodule
